// ===== hw/rtl/gbn_pkg.sv =====
// Shared types, codes and constants of the go-back-n sender.
package gbn_pkg;

  localparam int unsigned MAX_WINDOW     = 64;
  localparam int unsigned CHUNK_LIMIT    = 20000;
  localparam int unsigned TEARDOWN_COUNT = 3;

  localparam int unsigned CHUNK_W  = 15;
  localparam int unsigned WINDOW_W = 7;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned TRIES_W  = 4;
  localparam int unsigned CFG_W    = 32;
  localparam int unsigned CNT_W    = $clog2(MAX_WINDOW + 1);
  localparam int unsigned PROD_W   = WORD_W + CHUNK_W;

  localparam int unsigned DIV_STEPS = WORD_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [WORD_W-1:0] ACK_TYPE_DATA = 32'd2;

  typedef enum logic [1:0] {
    MODE_START   = 2'd0,
    MODE_ACK     = 2'd1,
    MODE_TIMEOUT = 2'd2
  } gbn_mode_e;

  typedef enum logic [1:0] {
    KIND_DATA     = 2'd0,
    KIND_TEARDOWN = 2'd1,
    KIND_GIVEUP   = 2'd2
  } gbn_kind_e;

  typedef enum logic [1:0] {
    CFG_CHUNK_SIZE  = 2'd0,
    CFG_WINDOW_SIZE = 2'd1,
    CFG_TOTAL_BYTES = 2'd2,
    CFG_MAX_TRIES   = 2'd3
  } gbn_cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_WINIT,
    ST_MUL,
    ST_EMIT,
    ST_TEAR,
    ST_GIVEUP
  } gbn_state_e;

  typedef enum logic {
    OP_START,
    OP_WINDOW
  } gbn_op_e;

  typedef struct packed {
    logic               start;
    logic [WORD_W-1:0]  dividend;
    logic [CHUNK_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [WORD_W-1:0]  quotient;
    logic [CHUNK_W-1:0] remainder;
  } div_rsp_t;

endpackage

// ===== hw/rtl/gbn_if.sv =====
// Event and result channel interfaces of the go-back-n sender.
interface gbn_evt_if;
  import gbn_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [1:0]               mode;
  logic [WORD_W-1:0]        ack_type;
  logic signed [WORD_W-1:0] ack_seq;

  modport source (output valid, mode, ack_type, ack_seq, input ready);
  modport sink   (input valid, mode, ack_type, ack_seq, output ready);
endinterface

interface gbn_res_if;
  import gbn_pkg::*;

  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [WORD_W-1:0]  seq_no;
  logic [CHUNK_W-1:0] length;
  logic [WORD_W-1:0]  byte_offset;
  logic               last;

  modport source (output valid, kind, seq_no, length, byte_offset, last, input ready);
  modport sink   (input valid, kind, seq_no, length, byte_offset, last, output ready);
endinterface

// ===== hw/rtl/gbn_div.sv =====
// Restoring divider, one quotient bit a cycle, 32-bit dividend by 15-bit divisor.
module gbn_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gbn_pkg::div_req_t req_i,
  output gbn_pkg::div_rsp_t rsp_o
);
  import gbn_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [CHUNK_W-1:0]   rem_q, rem_d;
  logic [WORD_W-1:0]    quo_q, quo_d;
  logic [CHUNK_W-1:0]   dvs_q, dvs_d;
  logic [CHUNK_W:0]     trial;
  logic                 fits;

  // remainder stays below the divisor, so the shifted trial fits in 16 bits
  assign trial = {rem_q, quo_q[WORD_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = fits ? CHUNK_W'(trial - {1'b0, dvs_q}) : trial[CHUNK_W-1:0];
      quo_d = {quo_q[WORD_W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

// ===== hw/rtl/go_back_n_sender.sv =====
// Go-back-n sender window control: sequencer, window state and result register.
//
//  channel   | dir | handshake     | payload
//  ----------+-----+---------------+---------------------------------------------
//  evt_i     | in  | valid/ready   | mode, ack_type, ack_seq
//  res_o     | out | valid/ready   | kind, seq_no, length, byte_offset, last
//  cfg_*     | in  | write enable  | cfg_idx_i selects register, cfg_wdata_i data
//
// One event is taken at a time: ready is high only while the sequencer idles.
// Start and window-emitting events run the shared 32-step divider (ceiling count
// and tail length).
// Each data descriptor passes the single 32x15 offset multiplier, then the result
// register; a stalled sink holds the sequencer in whichever output step it is in.
// Reset is asynchronous; no clearing pass is needed.
module go_back_n_sender (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  gbn_evt_if.sink                     evt_i,
  gbn_res_if.source                   res_o,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [gbn_pkg::CFG_W-1:0]   cfg_wdata_i
);
  import gbn_pkg::*;

  // configuration registers
  logic [CHUNK_W-1:0]  chunk_q;
  logic [WINDOW_W-1:0] window_q;
  logic [WORD_W-1:0]   total_q;
  logic [TRIES_W-1:0]  max_tries_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_q     <= CHUNK_W'(1024);
      window_q    <= WINDOW_W'(8);
      total_q     <= '0;
      max_tries_q <= TRIES_W'(10);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CHUNK_SIZE:  chunk_q     <= cfg_wdata_i[CHUNK_W-1:0];
        CFG_WINDOW_SIZE: window_q    <= cfg_wdata_i[WINDOW_W-1:0];
        CFG_TOTAL_BYTES: total_q     <= cfg_wdata_i[WORD_W-1:0];
        CFG_MAX_TRIES:   max_tries_q <= cfg_wdata_i[TRIES_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped chunk and window
  logic [CHUNK_W-1:0]  chunk_eff;
  logic [WINDOW_W-1:0] win_eff;

  always_comb begin
    if (chunk_q == '0)                         chunk_eff = CHUNK_W'(1);
    else if (chunk_q > CHUNK_W'(CHUNK_LIMIT))  chunk_eff = CHUNK_W'(CHUNK_LIMIT);
    else                                       chunk_eff = chunk_q;
    if (window_q == '0)                        win_eff = WINDOW_W'(1);
    else if (window_q > WINDOW_W'(MAX_WINDOW)) win_eff = WINDOW_W'(MAX_WINDOW);
    else                                       win_eff = window_q;
  end

  // sequencer and window state
  gbn_state_e state_q, state_d;
  gbn_op_e    op_q, op_d;

  logic                     active_q, active_d;
  logic [WORD_W-1:0]        base_q, base_d;
  logic signed [WORD_W:0]   ha_q, ha_d;      // highest acked, -1 after start
  logic signed [WORD_W:0]   hs_q, hs_d;      // highest sent, -1 after start
  logic [TRIES_W-1:0]       retry_q, retry_d;
  logic [WORD_W-1:0]        pc_q, pc_d;      // packet count
  logic [CNT_W-1:0]         cnt_q, cnt_d;

  // latched event
  logic [1:0]               item_mode_q;
  logic [WORD_W-1:0]        item_type_q;
  logic signed [WORD_W-1:0] item_seq_q;

  // descriptor datapath
  logic [CHUNK_W-1:0] rem_q, rem_d;          // total bytes mod chunk
  logic [PROD_W-1:0]  prod_q, prod_d;        // full byte offset
  logic [WORD_W-1:0]  seq_q, seq_d;
  logic               last_q, last_d;

  // result register
  logic               out_valid_q, out_valid_d;
  gbn_kind_e          out_kind_q, out_kind_d;
  logic [WORD_W-1:0]  out_seq_q, out_seq_d;
  logic [CHUNK_W-1:0] out_len_q, out_len_d;
  logic [WORD_W-1:0]  out_off_q, out_off_d;
  logic               out_last_q, out_last_d;
  logic               out_load;
  logic               slot_free;

  div_req_t div_req;
  div_rsp_t div_rsp;

  gbn_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // event decode helpers
  logic signed [WORD_W:0]   ack_seq_x;
  logic signed [WORD_W:0]   ha_inc;
  logic signed [WORD_W:0]   ha_inc2;
  logic signed [WORD_W+1:0] last_idx;        // packet count minus one
  logic                     ack_take;
  logic                     ack_done;
  logic [TRIES_W-1:0]       retry_inc;
  logic                     give_up;
  logic [WORD_W-1:0]        pc_new;

  assign ack_seq_x = {item_seq_q[WORD_W-1], item_seq_q};
  assign ha_inc    = ha_q + 33'sd1;
  assign ha_inc2   = ha_q + 33'sd2;
  assign last_idx  = $signed({2'b00, pc_q}) - 34'sd1;
  assign ack_take  = (item_type_q == ACK_TYPE_DATA) && (ack_seq_x > ha_q);
  assign ack_done  = $signed({ha_inc[WORD_W], ha_inc}) >= last_idx;
  assign retry_inc = (retry_q == '1) ? retry_q : retry_q + 1'b1;
  assign give_up   = retry_inc >= max_tries_q;
  assign pc_new    = div_rsp.quotient + WORD_W'(div_rsp.remainder != '0);

  // window bookkeeping: highest sent ends at the last sequence of the burst,
  // clamped to the final packet
  logic signed [WORD_W+1:0] top_seq;
  logic signed [WORD_W+1:0] hs_x;
  logic signed [WORD_W+1:0] hs_max;
  logic signed [WORD_W+1:0] hs_min;

  assign top_seq = $signed({2'b00, base_q}) + $signed({27'b0, win_eff}) - 34'sd1;
  assign hs_x    = {hs_q[WORD_W], hs_q};
  assign hs_max  = (hs_x > top_seq) ? hs_x : top_seq;
  assign hs_min  = (hs_max > last_idx) ? last_idx : hs_max;

  // descriptor sequence and length choice
  logic [WORD_W:0]   seq33;
  logic [PROD_W:0]   need;
  logic [CHUNK_W-1:0] len_sel;

  assign seq33   = {1'b0, base_q} + {{(WORD_W + 1 - CNT_W){1'b0}}, cnt_q};
  assign need    = {1'b0, prod_q} + {{(PROD_W + 1 - CHUNK_W){1'b0}}, chunk_eff};
  assign len_sel = ({{(PROD_W + 1 - WORD_W){1'b0}}, total_q} >= need) ? chunk_eff : rem_q;

  assign slot_free = !out_valid_q || res_o.ready;

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    active_d   = active_q;
    base_d     = base_q;
    ha_d       = ha_q;
    hs_d       = hs_q;
    retry_d    = retry_q;
    pc_d       = pc_q;
    cnt_d      = cnt_q;
    rem_d      = rem_q;
    prod_d     = prod_q;
    seq_d      = seq_q;
    last_d     = last_q;
    out_load   = 1'b0;
    out_kind_d = out_kind_q;
    out_seq_d  = out_seq_q;
    out_len_d  = out_len_q;
    out_off_d  = out_off_q;
    out_last_d = out_last_q;

    div_req.start    = 1'b0;
    div_req.dividend = total_q;
    div_req.divisor  = chunk_eff;

    case (state_q)
      ST_IDLE: begin
        if (evt_i.valid) state_d = ST_EVAL;
      end

      ST_EVAL: begin
        state_d = ST_IDLE;
        case (item_mode_q)
          MODE_START: begin
            div_req.start = 1'b1;
            op_d          = OP_START;
            state_d       = ST_DIV;
          end
          MODE_ACK: begin
            if (active_q && ack_take) begin
              ha_d    = ha_inc;
              base_d  = ha_inc2[WORD_W-1:0];
              retry_d = '0;
              if (ack_done) begin
                active_d = 1'b0;
                cnt_d    = '0;
                state_d  = ST_TEAR;
              end else if (ha_inc == hs_q) begin
                div_req.start = 1'b1;
                op_d          = OP_WINDOW;
                state_d       = ST_DIV;
              end
            end
          end
          MODE_TIMEOUT: begin
            if (active_q) begin
              retry_d = retry_inc;
              if (give_up) begin
                active_d = 1'b0;
                state_d  = ST_GIVEUP;
              end else begin
                div_req.start = 1'b1;
                op_d          = OP_WINDOW;
                state_d       = ST_DIV;
              end
            end
          end
          default: ;
        endcase
      end

      ST_DIV: begin
        if (div_rsp.done) begin
          rem_d   = div_rsp.remainder;
          state_d = ST_WINIT;
          if (op_q == OP_START) begin
            pc_d    = pc_new;
            base_d  = '0;
            ha_d    = '1;
            hs_d    = '1;
            retry_d = '0;
            if (pc_new == '0) begin
              // empty transfer: straight to teardown
              active_d = 1'b0;
              cnt_d    = '0;
              state_d  = ST_TEAR;
            end else begin
              active_d = 1'b1;
            end
          end
        end
      end

      ST_WINIT: begin
        hs_d    = hs_min[WORD_W:0];
        cnt_d   = '0;
        state_d = ST_MUL;
      end

      ST_MUL: begin
        seq_d   = seq33[WORD_W-1:0];
        prod_d  = seq33[WORD_W-1:0] * chunk_eff;
        last_d  = (cnt_q == CNT_W'(win_eff - 1'b1)) ||
                  ((seq33 + 1'b1) == {1'b0, pc_q});
        state_d = ST_EMIT;
      end

      ST_EMIT: begin
        if (slot_free) begin
          out_load   = 1'b1;
          out_kind_d = KIND_DATA;
          out_seq_d  = seq_q;
          out_len_d  = len_sel;
          out_off_d  = prod_q[WORD_W-1:0];
          out_last_d = last_q;
          if (last_q) begin
            state_d = ST_IDLE;
          end else begin
            cnt_d   = cnt_q + 1'b1;
            state_d = ST_MUL;
          end
        end
      end

      ST_TEAR: begin
        if (slot_free) begin
          out_load   = 1'b1;
          out_kind_d = KIND_TEARDOWN;
          out_seq_d  = '0;
          out_len_d  = '0;
          out_off_d  = '0;
          out_last_d = (cnt_q == CNT_W'(TEARDOWN_COUNT - 1));
          if (cnt_q == CNT_W'(TEARDOWN_COUNT - 1)) state_d = ST_IDLE;
          else                                     cnt_d   = cnt_q + 1'b1;
        end
      end

      ST_GIVEUP: begin
        if (slot_free) begin
          out_load   = 1'b1;
          out_kind_d = KIND_GIVEUP;
          out_seq_d  = '0;
          out_len_d  = '0;
          out_off_d  = '0;
          out_last_d = 1'b1;
          state_d    = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase

    if (out_load)         out_valid_d = 1'b1;
    else if (res_o.ready) out_valid_d = 1'b0;
    else                  out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_START;
      active_q    <= 1'b0;
      base_q      <= '0;
      ha_q        <= '1;
      hs_q        <= '1;
      retry_q     <= '0;
      pc_q        <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      active_q    <= active_d;
      base_q      <= base_d;
      ha_q        <= ha_d;
      hs_q        <= hs_d;
      retry_q     <= retry_d;
      pc_q        <= pc_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (evt_i.valid && evt_i.ready) begin
      item_mode_q <= evt_i.mode;
      item_type_q <= evt_i.ack_type;
      item_seq_q  <= evt_i.ack_seq;
    end
    rem_q      <= rem_d;
    prod_q     <= prod_d;
    seq_q      <= seq_d;
    last_q     <= last_d;
    out_kind_q <= out_kind_d;
    out_seq_q  <= out_seq_d;
    out_len_q  <= out_len_d;
    out_off_q  <= out_off_d;
    out_last_q <= out_last_d;
  end

  assign evt_i.ready       = (state_q == ST_IDLE);
  assign res_o.valid       = out_valid_q;
  assign res_o.kind        = out_kind_q;
  assign res_o.seq_no      = out_seq_q;
  assign res_o.length      = out_len_q;
  assign res_o.byte_offset = out_off_q;
  assign res_o.last        = out_last_q;

  // divider only reports back while the sequencer waits on it
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == ST_DIV)
    else $error("divider done outside divide step");

  // a live transfer always has packets
  a_active_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> pc_q != '0)
    else $error("active transfer with zero packet count");

  // highest sent never passes the final packet
  a_hs_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> $signed({hs_q[WORD_W], hs_q}) <= last_idx)
    else $error("highest sent beyond final packet");

  // every descriptor built lies inside the transfer
  a_seq_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MUL |-> seq33 < {1'b0, pc_q})
    else $error("descriptor sequence beyond packet count");

endmodule
